// ===== src/mpq_pkg.sv =====
// shared types and constants for the multilevel priority fifo queue
`default_nettype none

package mpq_pkg;

    localparam int unsigned LEVELS_DEF       = 8;
    localparam int unsigned LEVEL_DEPTH_DEF  = 16;
    localparam int unsigned VALUE_BITS_DEF   = 32;

    localparam int unsigned ITEM_BITS        = 32;
    localparam int unsigned LEVEL_FIELD_BITS = 3;
    localparam int unsigned STATUS_BITS      = 2;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // command broadcast to every cell in the row
    typedef struct packed {
        logic                        enq;
        logic                        deq;
        logic [LEVEL_FIELD_BITS-1:0] level;
    } t_cell_cmd;

    // flags rippling from level 0 upward through the row
    typedef struct packed {
        logic found;   // some lower level holds a word
        logic stored;  // some lower level took the enqueued word
    } t_chain;

endpackage

`default_nettype wire

// ===== src/mpq_if.sv =====
// valid/ready channel interfaces for input and result words
`default_nettype none

interface mpq_in_if;
    logic                                    valid;
    logic                                    ready;
    mpq_pkg::t_op                            operation;
    logic signed [mpq_pkg::ITEM_BITS-1:0]    item_value;
    logic [mpq_pkg::LEVEL_FIELD_BITS-1:0]    priority_level;

    modport source (output valid, output operation, output item_value,
                    output priority_level, input ready);
    modport sink   (input valid, input operation, input item_value,
                    input priority_level, output ready);
endinterface

interface mpq_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mpq_pkg::ITEM_BITS-1:0]    head_value;
    logic                                    head_valid;
    mpq_pkg::t_status                        status;

    modport source (output valid, output head_value, output head_valid,
                    output status, input ready);
    modport sink   (input valid, input head_value, input head_valid,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== src/multilevel_priority_fifo_queue_top.sv =====
// strict-priority queue: a row of per-level fifo cells with a result register
// result path: the cell row updates on accept, the head is picked while r_busy is set,
//   and the word is then offered from the result register; no new word is taken while
//   r_busy is set or while a result word waits untaken
// reset: synchronous active low, clears pointers, fill counts and handshake;
//   level storage is not cleared
`default_nettype none

module multilevel_priority_fifo_queue_top #(
    parameter int unsigned LEVELS      = mpq_pkg::LEVELS_DEF,
    parameter int unsigned LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF,
    parameter int unsigned VALUE_BITS  = mpq_pkg::VALUE_BITS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    mpq_in_if.sink    i_in,
    mpq_out_if.source o_out
);

    mpq_pkg::t_chain       w_chain [LEVELS+1];
    logic [VALUE_BITS-1:0] w_head  [LEVELS+1];

    mpq_pkg::t_cell_cmd    cmd;
    logic [VALUE_BITS-1:0] value_ext;
    logic                  accept;
    mpq_pkg::t_status      n_status;

    logic                  r_busy;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_head;
    logic                  r_out_hv;
    mpq_pkg::t_status      r_status;

    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    assign value_ext  = VALUE_BITS'(i_in.item_value);
    assign cmd.enq    = accept && (i_in.operation == mpq_pkg::OP_ENQUEUE);
    assign cmd.deq    = accept && (i_in.operation == mpq_pkg::OP_DEQUEUE);
    assign cmd.level  = i_in.priority_level;

    assign w_chain[0] = '0;
    assign w_head[0]  = '0;

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        mpq_cell #(
            .CELL_INDEX  (g),
            .LEVEL_DEPTH (LEVEL_DEPTH),
            .VALUE_BITS  (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_value      (value_ext),
            .i_chain      (w_chain[g]),
            .i_head_chain (w_head[g]),
            .o_chain      (w_chain[g+1]),
            .o_head_chain (w_head[g+1])
        );
    end

    // status comes from the row state seen in the accept cycle
    always_comb begin
        if (cmd.deq) begin
            n_status = w_chain[LEVELS].found ? mpq_pkg::ST_OK : mpq_pkg::ST_UNDERFLOW;
        end else begin
            n_status = w_chain[LEVELS].stored ? mpq_pkg::ST_OK : mpq_pkg::ST_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= accept;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // head is picked from the updated row in the cycle after accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (r_busy) begin
            r_out_hv   <= w_chain[LEVELS].found;
            r_out_head <= w_chain[LEVELS].found ? w_head[LEVELS] : '0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.head_value = mpq_pkg::ITEM_BITS'(r_out_head);
    assign o_out.head_valid = r_out_hv;
    assign o_out.status     = r_status;

endmodule

`default_nettype wire

// ===== src/mpq_cell.sv =====
// one priority level: a small fifo with its own head register and chain links
`default_nettype none

module mpq_cell #(
    parameter int unsigned CELL_INDEX  = 0,
    parameter int unsigned LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF,
    parameter int unsigned VALUE_BITS  = mpq_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mpq_pkg::t_cell_cmd    i_cmd,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire mpq_pkg::t_chain       i_chain,
    input  wire logic [VALUE_BITS-1:0] i_head_chain,
    output mpq_pkg::t_chain            o_chain,
    output logic [VALUE_BITS-1:0]      o_head_chain
);

    localparam int unsigned PTR_BITS = $clog2(LEVEL_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(LEVEL_DEPTH + 1);

    logic [VALUE_BITS-1:0] r_mem [LEVEL_DEPTH];
    logic [VALUE_BITS-1:0] r_head;
    logic [PTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CNT_BITS-1:0]   r_count, n_count;

    logic targeted, nonempty, full, do_write, do_take;
    logic [PTR_BITS-1:0] rd_inc, wr_inc;

    assign targeted = (32'(i_cmd.level) == 32'(CELL_INDEX));
    assign nonempty = (r_count != '0);
    assign full     = (r_count == CNT_BITS'(LEVEL_DEPTH));
    assign do_write = i_cmd.enq && targeted && !full;
    // only the lowest busy level gives up its head
    assign do_take  = i_cmd.deq && nonempty && !i_chain.found;

    assign rd_inc = (r_rd_ptr == PTR_BITS'(LEVEL_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign wr_inc = (r_wr_ptr == PTR_BITS'(LEVEL_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (do_write) begin
            n_wr_ptr = wr_inc;
            n_count  = r_count + 1'b1;
        end else if (do_take) begin
            n_rd_ptr = rd_inc;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr_ptr] <= i_value;
        end
    end

    // head register tracks the front word; empty fifo takes the word directly
    always_ff @(posedge i_clk) begin
        if (do_write && !nonempty) begin
            r_head <= i_value;
        end else if (do_take) begin
            r_head <= r_mem[rd_inc];
        end
    end

    assign o_chain.found  = i_chain.found || nonempty;
    assign o_chain.stored = i_chain.stored || do_write;
    assign o_head_chain   = i_chain.found ? i_head_chain : r_head;

endmodule

`default_nettype wire

// ===== src/mpq_checker.sv =====
// port-level checks for the priority queue, bound to the top level
`default_nettype none

module mpq_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [mpq_pkg::ITEM_BITS-1:0]    i_head_value,
    input wire logic                             i_head_valid,
    input wire mpq_pkg::t_status                 i_status
);

    // one word in flight: the cycle after an accept never accepts
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("word accepted right after another");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == mpq_pkg::ST_UNDERFLOW)) |-> !i_head_valid)
        else $error("underflow reported with a valid head");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_head_valid) |-> (i_head_value == '0))
        else $error("empty queue shows nonzero head");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_head_value)
            && $stable(i_head_valid) && $stable(i_status)))
        else $error("stalled result word changed");

endmodule

bind multilevel_priority_fifo_queue_top mpq_checker u_mpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_head_value (o_out.head_value),
    .i_head_valid (o_out.head_valid),
    .i_status     (o_out.status)
);

`default_nettype wire

// ===== dv/multilevel_priority_fifo_queue_top_tb.sv =====
// self-checking testbench for the multilevel priority fifo queue top level
`default_nettype none

module multilevel_priority_fifo_queue_top_tb;

    import mpq_pkg::*;

    localparam int LEVELS       = LEVELS_DEF;
    localparam int LEVEL_DEPTH  = LEVEL_DEPTH_DEF;
    localparam int TOTAL_WORDS  = 1650;
    localparam int TAIL_WORDS   = 200;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_op                         op;
        logic [ITEM_BITS-1:0]        value;
        logic [LEVEL_FIELD_BITS-1:0] level;
    } t_cmd;

    typedef struct packed {
        logic signed [ITEM_BITS-1:0] head_value;
        logic                        head_valid;
        t_status                     status;
    } t_head_word;

    logic i_clk;
    logic i_rst_n;

    mpq_in_if  in_ch ();
    mpq_out_if out_ch ();

    multilevel_priority_fifo_queue_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // software copy of the per-level fifos
    logic [ITEM_BITS-1:0] level_slot [LEVELS][LEVEL_DEPTH];
    int level_rd   [LEVELS];
    int level_wr   [LEVELS];
    int level_fill [LEVELS];

    t_cmd       pending_cmds [$];
    t_head_word expected_heads [$];

    int   accepted_words = 0;
    int   results_seen   = 0;
    int   mismatches     = 0;
    int   enq_count      = 0;
    int   deq_count      = 0;
    int   drop_count     = 0;
    int   empty_deq_count = 0;
    int   send_gap       = 0;
    int   sink_gap       = 0;
    int   hold_left      = 0;
    bit   hold_done      = 0;
    int   cycle_count    = 0;
    logic tail_phase     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // lowest non-empty level, LEVELS when all are empty
    function automatic int busiest_level();
        for (int lv = 0; lv < LEVELS; lv++) begin
            if (level_fill[lv] != 0) return lv;
        end
        return LEVELS;
    endfunction

    function automatic void advance_queue_model(t_op op, logic [ITEM_BITS-1:0] value,
                                                logic [LEVEL_FIELD_BITS-1:0] level);
        t_head_word w;
        int top;
        int lv;
        w.status = ST_OK;
        lv = int'(level);
        if (op == OP_ENQUEUE) begin
            enq_count++;
            if (lv >= LEVELS || level_fill[lv] >= LEVEL_DEPTH) begin
                w.status = ST_OVERFLOW;
                drop_count++;
            end else begin
                level_slot[lv][level_wr[lv]] = value;
                level_wr[lv] = (level_wr[lv] + 1) % LEVEL_DEPTH;
                level_fill[lv]++;
            end
        end else begin
            deq_count++;
            top = busiest_level();
            if (top == LEVELS) begin
                w.status = ST_UNDERFLOW;
                empty_deq_count++;
            end else begin
                level_rd[top] = (level_rd[top] + 1) % LEVEL_DEPTH;
                level_fill[top]--;
            end
        end
        top = busiest_level();
        if (top < LEVELS) begin
            w.head_value = level_slot[top][level_rd[top]];
            w.head_valid = 1'b1;
        end else begin
            w.head_value = '0;
            w.head_valid = 1'b0;
        end
        expected_heads.push_back(w);
    endfunction

    function automatic void check_head(logic signed [ITEM_BITS-1:0] value, logic valid,
                                       t_status st);
        t_head_word want;
        results_seen++;
        if (expected_heads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word %0d unexpected: head %0d valid %0b status %0d",
                         results_seen, value, valid, st);
            return;
        end
        want = expected_heads.pop_front();
        if (want.head_value !== value || want.head_valid !== valid || want.status !== st) begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: want head %0d valid %0b st %0d, got %0d %0b %0d",
                         results_seen, want.head_value, want.head_valid, want.status,
                         value, valid, st);
        end
    endfunction

    function automatic void push_cmd(t_op op, logic [ITEM_BITS-1:0] value,
                                     logic [LEVEL_FIELD_BITS-1:0] level);
        t_cmd c;
        c.op    = op;
        c.value = value;
        c.level = level;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [ITEM_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // input side: one word offered at a time, random gaps between words
    always @(posedge i_clk) begin : word_driver
        t_cmd cmd;
        logic offer;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            offer = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                advance_queue_model(in_ch.operation, in_ch.item_value, in_ch.priority_level);
                accepted_words++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (pending_cmds.size() != 0) begin
                    cmd = pending_cmds.pop_front();
                    in_ch.operation      <= cmd.op;
                    in_ch.item_value     <= cmd.value;
                    in_ch.priority_level <= cmd.level;
                    offer = 1'b1;
                    if (!tail_phase && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 14);
                end
            end
            in_ch.valid <= offer;
            tail_phase  <= (pending_cmds.size() < TAIL_WORDS);
        end
    end

    // result side: check every taken word, stall in random bursts
    always @(posedge i_clk) begin : result_sink
        logic take;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                check_head(out_ch.head_value, out_ch.head_valid, out_ch.status);
            take = 1'b1;
            if (hold_left != 0) begin
                take = 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                take = 1'b0;
            end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 14) - 1;
                take = 1'b0;
            end
            out_ch.ready <= take;
        end
    end

    // one long receiver hold so the block backs up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words accepted, %0d results taken",
                     cycle_count, accepted_words, results_seen);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int seg;
        int enq_pct;
        int focus_pct;
        int focus;
        t_op op;
        logic [LEVEL_FIELD_BITS-1:0] lvl;

        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.operation       = OP_ENQUEUE;
        in_ch.item_value      = '0;
        in_ch.priority_level  = '0;
        out_ch.ready          = 1'b0;

        // directed: empty dequeue, value extremes, ordering across levels
        push_cmd(OP_DEQUEUE, 32'h0000_0000, 3'd0);
        push_cmd(OP_ENQUEUE, 32'h8000_0000, 3'd7);
        push_cmd(OP_ENQUEUE, 32'h7fff_ffff, 3'd0);
        push_cmd(OP_ENQUEUE, 32'hffff_ffff, 3'd0);
        push_cmd(OP_ENQUEUE, 32'h0000_0000, 3'd3);
        push_cmd(OP_DEQUEUE, 32'hffff_ffff, 3'd7);   // ignored fields set
        push_cmd(OP_DEQUEUE, 32'h1234_5678, 3'd5);
        push_cmd(OP_DEQUEUE, 32'h0000_0000, 3'd0);
        push_cmd(OP_DEQUEUE, 32'h0000_0000, 3'd0);
        push_cmd(OP_DEQUEUE, 32'hdead_beef, 3'd6);
        // fill one level to the brim, then one more is dropped
        for (int k = 0; k < LEVEL_DEPTH; k++)
            push_cmd(OP_ENQUEUE, (k % 2) ? 32'haaaa_aaaa : 32'h5555_5555, 3'd5);
        push_cmd(OP_ENQUEUE, 32'h0bad_f00d, 3'd5);

        // random: fill, drain and mixed segments, often aimed at one level
        while (pending_cmds.size() < TOTAL_WORDS) begin
            seg   = $urandom_range(20, 80);
            focus = $urandom_range(0, LEVELS - 1);
            case ($urandom_range(0, 3))
                0: begin enq_pct = 85; focus_pct = 70; end
                1: begin enq_pct = 20; focus_pct = 0;  end
                default: begin enq_pct = 55; focus_pct = 30; end
            endcase
            for (int k = 0; k < seg && pending_cmds.size() < TOTAL_WORDS; k++) begin
                op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                lvl = ($urandom_range(0, 99) < focus_pct)
                    ? focus[LEVEL_FIELD_BITS-1:0]
                    : LEVEL_FIELD_BITS'($urandom_range(0, LEVELS - 1));
                push_cmd(op, pick_value(), lvl);
            end
        end
        seg = pending_cmds.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_words != seg) @(posedge i_clk);
        while (expected_heads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("covered %0d words: %0d enq (%0d dropped), %0d deq (%0d on empty queue)",
                 accepted_words, enq_count, drop_count, deq_count, empty_deq_count);
        $display("results checked %0d, mismatches %0d, words still expected %0d",
                 results_seen, mismatches, expected_heads.size());
        if (mismatches == 0 && expected_heads.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
